### design/bb3_pkg.sv
// Shared types and constants for the 3x3 RGB box blur.
// Used by the line buffer RAM and the top level; depends on nothing.
package bb3_pkg;

    localparam int CHAN_W      = 8;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 12;
    localparam int WIDTH_W     = 11;
    localparam int GAIN_W      = 13;
    localparam int MAX_WIDTH   = 1 << COL_W;
    localparam int MAX_ROWS    = 1 << ROW_W;
    localparam int MIN_WIDTH   = 3;
    localparam int WIDTH_RESET = 640;
    localparam int GAIN_RESET  = 7209;
    localparam int CSUM_W      = CHAN_W + 2;     // sum of one 3-pixel column
    localparam int SUM_W       = CHAN_W + 4;     // sum of the 3x3 window
    localparam int PROD_W      = SUM_W + GAIN_W;
    localparam int FRAC_W      = 16;
    localparam int PADDR_W     = 3;
    localparam int REG_SEL_BIT = 2;

    typedef enum logic {
        REG_IMAGE_WIDTH = 1'b0,
        REG_GAIN        = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_rgb;

    // One line buffer entry: pixel two rows up and pixel one row up.
    typedef struct packed {
        t_rgb upper;
        t_rgb lower;
    } t_line_entry;

    typedef logic [2:0][CSUM_W-1:0] t_col_sum;   // per channel, red at index 0

endpackage

### design/rgb_box_blur_3x3_unit.sv
// 3x3 mean blur of a raster-order RGB pixel stream: top level.
// Depends on bb3_pkg and bb3_line_ram.
//
// Usage:
//  - Slave stream carries one pixel per transfer: tdata = {blue, green, red},
//    tuser = frame start (that pixel becomes row 0, column 0).
//  - Master stream carries one filtered pixel per interior centre, with its
//    row and column. Border pixels produce no transfer.
//  - APB port: register 0 (byte 0x0) image width, clamped to 3..1024 in use;
//    register 1 (byte 0x4) Q0.16 gain. Write only while the stream is idle.
//  - Throughput: one pixel per clock, barring stalls. The single line buffer RAM
//    is read and written once per pixel; a back-to-back reuse of the same
//    column (repeated frame starts) is covered by a forwarding register.
//  - Pipeline: RAM read at the transfer edge, then column sums, window sum,
//    gain multiply, shift and saturate, each registered in turn.
//  - Stall: every stage holds while the next is full and stalled; border
//    pixels leave after stage 1, so the input keeps taking pixels until every
//    stage from the RAM read to the output register is full.
//  - Reset: pipeline empty, window cleared, position (0,0), width 640,
//    gain 7209. The line buffer is not cleared; every column is written on
//    the first row before it is read for a result.
module rgb_box_blur_3x3_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave stream
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [23:0]                 i_s_axis_tdata,  // red[7:0] green[15:8] blue[23:16]
    input  logic                        i_s_axis_tuser,  // frame_start
    // master stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [47:0]                 o_m_axis_tdata,  // out_red[7:0] out_green[15:8]
                                                         // out_blue[23:16] centre_row[35:24]
                                                         // centre_col[45:36] zero[47:46]
    // APB configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bb3_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import bb3_pkg::*;

    // configuration
    logic [WIDTH_W-1:0] r_cfg_width;
    logic [GAIN_W-1:0]  r_cfg_gain;
    logic               cfg_wr;
    t_reg_idx           reg_idx;

    // pipeline handshake
    logic load1, load2, load3, load4, load_o, acc, adv1;
    logic r_v1, r_v2, r_v3, r_v4, r_vo;

    // position
    logic [COL_W-1:0]   r_col, n_col, col_base, col_eff;
    logic [ROW_W-1:0]   r_row, n_row, row_eff;
    logic [WIDTH_W-1:0] width_eff;
    logic               emit;

    // stage 1: RAM read
    t_rgb               r_s1_px;
    logic [COL_W-1:0]   r_s1_col;
    logic [ROW_W-1:0]   r_s1_row;
    logic               r_s1_emit;
    logic               r_fwd_hit;
    t_line_entry        r_fwd_data;
    t_line_entry        ram_q, line_eff, wr_data;

    // window as three column sums, oldest at index 0
    t_col_sum           r_cs [3];
    t_col_sum           new_cs;

    // stage 2..4 and output
    t_col_sum           r_s2_a, r_s2_b, r_s2_c;
    logic [SUM_W-1:0]   r_s3_sum  [3];
    logic [PROD_W-1:0]  r_s4_prod [3];
    logic [ROW_W-1:0]   r_s2_row, r_s3_row, r_s4_row, r_out_row;
    logic [COL_W-1:0]   r_s2_col, r_s3_col, r_s4_col, r_out_col;
    logic [CHAN_W-1:0]  r_out_ch [3];

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[REG_SEL_BIT]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width <= WIDTH_W'(WIDTH_RESET);
            r_cfg_gain  <= GAIN_W'(GAIN_RESET);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_IMAGE_WIDTH: r_cfg_width <= pwdata[WIDTH_W-1:0];
                REG_GAIN:        r_cfg_gain  <= pwdata[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_IMAGE_WIDTH: prdata = 32'(r_cfg_width);
            REG_GAIN:        prdata = 32'(r_cfg_gain);
            default:         prdata = '0;
        endcase
    end

    // ---------------- handshake chain ----------------
    assign load_o = !r_vo | i_m_axis_tready;
    assign load4  = !r_v4 | load_o;
    assign load3  = !r_v3 | load4;
    assign load2  = !r_v2 | load3;
    assign load1  = !r_v1 | load2;
    assign acc    = i_s_axis_tvalid & load1;
    assign adv1   = r_v1 & load2;             // stage 1 pixel retires: RAM write, window shift

    assign o_s_axis_tready = load1;

    // ---------------- position counters ----------------
    always_comb begin
        if (r_cfg_width < WIDTH_W'(MIN_WIDTH)) begin
            width_eff = WIDTH_W'(MIN_WIDTH);
        end else if (r_cfg_width > WIDTH_W'(MAX_WIDTH)) begin
            width_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            width_eff = r_cfg_width;
        end

        col_base = i_s_axis_tuser ? '0 : r_col;
        row_eff  = i_s_axis_tuser ? '0 : r_row;
        // width may have shrunk since the counter advanced
        col_eff  = ({1'b0, col_base} >= width_eff) ? '0 : col_base;
        emit     = (row_eff >= ROW_W'(2)) && (col_eff >= COL_W'(2));

        if (({1'b0, col_eff} + WIDTH_W'(1)) >= width_eff) begin
            n_col = '0;
            n_row = (row_eff == ROW_W'(MAX_ROWS - 1)) ? '0 : row_eff + ROW_W'(1);
        end else begin
            n_col = col_eff + COL_W'(1);
            n_row = row_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- stage 1: line buffer read ----------------
    // entry = {row-2 pixel, row-1 pixel}; write back {row-1 pixel, new pixel}
    assign line_eff      = r_fwd_hit ? r_fwd_data : ram_q;
    assign wr_data.upper = line_eff.lower;
    assign wr_data.lower = r_s1_px;

    bb3_line_ram u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (adv1),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_data),
        .i_rd_en   (acc),
        .i_rd_addr (col_eff),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else if (load1) begin
            r_v1      <= i_s_axis_tvalid;
            // same column read while the previous pixel writes it
            r_fwd_hit <= acc && adv1 && (col_eff == r_s1_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_s1_px    <= i_s_axis_tdata;
            r_s1_col   <= col_eff;
            r_s1_row   <= row_eff;
            r_s1_emit  <= emit;
            r_fwd_data <= wr_data;
        end
    end

    // ---------------- window: column sums ----------------
    assign new_cs[0] = CSUM_W'(line_eff.upper.red)   + CSUM_W'(line_eff.lower.red)
                     + CSUM_W'(r_s1_px.red);
    assign new_cs[1] = CSUM_W'(line_eff.upper.green) + CSUM_W'(line_eff.lower.green)
                     + CSUM_W'(r_s1_px.green);
    assign new_cs[2] = CSUM_W'(line_eff.upper.blue)  + CSUM_W'(line_eff.lower.blue)
                     + CSUM_W'(r_s1_px.blue);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs[0] <= '0;
            r_cs[1] <= '0;
            r_cs[2] <= '0;
        end else if (adv1) begin
            r_cs[0] <= r_cs[1];
            r_cs[1] <= r_cs[2];
            r_cs[2] <= new_cs;
        end
    end

    // ---------------- stages 2..4 and output ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (load2)  r_v2 <= r_v1 & r_s1_emit;   // border pixels end here
            if (load3)  r_v3 <= r_v2;
            if (load4)  r_v4 <= r_v3;
            if (load_o) r_vo <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load2) begin
            r_s2_a   <= r_cs[1];
            r_s2_b   <= r_cs[2];
            r_s2_c   <= new_cs;
            r_s2_row <= r_s1_row - ROW_W'(1);
            r_s2_col <= r_s1_col - COL_W'(1);
        end
        if (load3) begin
            for (int c = 0; c < 3; c++) begin
                r_s3_sum[c] <= SUM_W'(r_s2_a[c]) + SUM_W'(r_s2_b[c]) + SUM_W'(r_s2_c[c]);
            end
            r_s3_row <= r_s2_row;
            r_s3_col <= r_s2_col;
        end
        if (load4) begin
            for (int c = 0; c < 3; c++) begin
                r_s4_prod[c] <= PROD_W'(r_s3_sum[c]) * PROD_W'(r_cfg_gain);
            end
            r_s4_row <= r_s3_row;
            r_s4_col <= r_s3_col;
        end
        if (load_o) begin
            // a gain above the nominal range can reach 256..286
            for (int c = 0; c < 3; c++) begin
                r_out_ch[c] <= r_s4_prod[c][FRAC_W+CHAN_W]
                             ? {CHAN_W{1'b1}}
                             : r_s4_prod[c][FRAC_W+CHAN_W-1:FRAC_W];
            end
            r_out_row <= r_s4_row;
            r_out_col <= r_s4_col;
        end
    end

    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = {2'b00, r_out_col, r_out_row,
                              r_out_ch[2], r_out_ch[1], r_out_ch[0]};

    // ---------------- assertions ----------------
    a_fwd_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_v1)
        else $error("forward hit with stage 1 empty");

    a_centre_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_s2_row != '0 && r_s2_col != '0))
        else $error("result centre on the border");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !load2) |=> (r_v1 && $stable(r_s1_col) && !$past(acc)))
        else $error("stage 1 lost or overwritten while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && !r_v2 && !r_vo))
        else $error("pipeline not empty after reset");

endmodule

### design/bb3_line_ram.sv
// Line buffer storage: one write port, one read port, registered read data.
// Depends on bb3_pkg for the entry type and address width.
module bb3_line_ram (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [bb3_pkg::COL_W-1:0] i_wr_addr,
    input  bb3_pkg::t_line_entry      i_wr_data,
    input  logic                      i_rd_en,
    input  logic [bb3_pkg::COL_W-1:0] i_rd_addr,
    output bb3_pkg::t_line_entry      o_rd_data
);
    import bb3_pkg::*;

    t_line_entry r_mem [MAX_WIDTH];
    t_line_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-during-write returns old data; the caller forwards
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### verif/tb.sv
// Self-checking testbench for rgb_box_blur_3x3_unit: stream pixels in, check blurred centres.
// Carries its own blur predictor, drives the APB registers and both stream sides.
// Depends on bb3_pkg and the design sources only.
module tb;
    import bb3_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYC  = 12;     // pipeline is 5 deep; margin on top
    localparam int MAX_REPORTS = 30;

    // one filtered centre pixel as the block reports it
    typedef struct {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } t_blur_out;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               s_valid = 1'b0;
    t_rgb               s_pixel = '0;
    logic               s_fstart = 1'b0;
    logic               m_ready = 1'b1;
    logic               apb_sel = 1'b0;
    logic               apb_en = 1'b0;
    logic               apb_wr = 1'b0;
    logic [PADDR_W-1:0] apb_addr = '0;
    logic [31:0]        apb_wdata = '0;

    logic               o_s_axis_tready;
    logic               o_m_axis_tvalid;
    logic [47:0]        o_m_axis_tdata;
    logic [31:0]        prdata;
    logic               pready;

    // predictor state: two line stores, 3x3 window, raster position, registers
    t_rgb               upper_line [MAX_WIDTH];
    t_rgb               lower_line [MAX_WIDTH];
    t_rgb               win_px [9];
    int unsigned        col_pos = 0;
    int unsigned        row_pos = 0;
    logic [WIDTH_W-1:0] cfg_width = WIDTH_W'(WIDTH_RESET);
    logic [GAIN_W-1:0]  cfg_gain = GAIN_W'(GAIN_RESET);

    t_blur_out          blurred_q [$];
    t_blur_out          blur_want;
    int                 mismatches = 0;
    int                 cycles = 0;
    int                 pixels_sent = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;

    rgb_box_blur_3x3_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_pixel),      // red[7:0] green[15:8] blue[23:16]
        .i_s_axis_tuser  (s_fstart),     // frame_start
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata), // red green blue row[35:24] col[45:36] pad
        .psel            (apb_sel),
        .penable         (apb_en),
        .pwrite          (apb_wr),
        .paddr           (apb_addr),
        .pwdata          (apb_wdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        m_ready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    // width register as the block uses it: clamped to 3..MAX_WIDTH
    function automatic int unsigned eff_width(logic [WIDTH_W-1:0] w);
        if (w < MIN_WIDTH)
            return MIN_WIDTH;
        if (w > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(w);
    endfunction

    // ch: 0 red, 1 green, 2 blue (same order as the tdata bytes)
    function automatic logic [CHAN_W-1:0] window_mean(int ch);
        logic [23:0]     p;
        int unsigned     sum;
        longint unsigned v;
        sum = 0;
        for (int i = 0; i < 9; i++) begin
            p = win_px[i];
            sum += p[ch*CHAN_W +: CHAN_W];
        end
        v = (longint'(sum) * longint'(cfg_gain)) >> FRAC_W;
        return (v > 255) ? 8'd255 : v[CHAN_W-1:0];   // only gains above 7310 can saturate
    endfunction

    // advance the model by one accepted pixel; queue a result for interior centres
    function automatic void blur_step(t_rgb px, logic fs);
        int unsigned w;
        t_blur_out   r;
        w = eff_width(cfg_width);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w)
            col_pos = 0;
        // window rows top..bottom, columns left..right; only original pixels enter
        win_px[0] = win_px[1];
        win_px[1] = win_px[2];
        win_px[2] = upper_line[col_pos];
        win_px[3] = win_px[4];
        win_px[4] = win_px[5];
        win_px[5] = lower_line[col_pos];
        win_px[6] = win_px[7];
        win_px[7] = win_px[8];
        win_px[8] = px;
        upper_line[col_pos] = lower_line[col_pos];
        lower_line[col_pos] = px;
        if (row_pos >= 2 && col_pos >= 2) begin
            r.red   = window_mean(0);
            r.green = window_mean(1);
            r.blue  = window_mean(2);
            r.row   = ROW_W'(row_pos - 1);
            r.col   = COL_W'(col_pos - 1);
            blurred_q.push_back(r);
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= MAX_ROWS) ? 0 : row_pos + 1;   // row wrap
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    //------------------------------------------------------------------
    // Checking
    //------------------------------------------------------------------

    task automatic flag_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // every output transfer is matched against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (blurred_q.size() == 0) begin
                flag_mismatch("unexpected result, tdata", o_m_axis_tdata, 0);
            end else begin
                blur_want = blurred_q.pop_front();
                if (o_m_axis_tdata[7:0] !== blur_want.red)
                    flag_mismatch("out_red", o_m_axis_tdata[7:0], blur_want.red);
                if (o_m_axis_tdata[15:8] !== blur_want.green)
                    flag_mismatch("out_green", o_m_axis_tdata[15:8], blur_want.green);
                if (o_m_axis_tdata[23:16] !== blur_want.blue)
                    flag_mismatch("out_blue", o_m_axis_tdata[23:16], blur_want.blue);
                if (o_m_axis_tdata[35:24] !== blur_want.row)
                    flag_mismatch("centre_row", o_m_axis_tdata[35:24], blur_want.row);
                if (o_m_axis_tdata[45:36] !== blur_want.col)
                    flag_mismatch("centre_col", o_m_axis_tdata[45:36], blur_want.col);
                if (o_m_axis_tdata[47:46] !== 2'b00)
                    flag_mismatch("tdata pad bits", o_m_axis_tdata[47:46], 0);
            end
        end
    end

    //------------------------------------------------------------------
    // Drivers
    //------------------------------------------------------------------

    // one pixel transfer, with an optional random gap ahead of it
    task automatic push_pixel(t_rgb px, logic fs);
        int gap;
        gap = (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) ?
              $urandom_range(1, 3) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
        end
        @(negedge i_clk);
        s_valid  <= 1'b1;
        s_pixel  <= px;
        s_fstart <= fs;
        do @(posedge i_clk); while (!o_s_axis_tready);
        blur_step(px, fs);
        pixels_sent++;
    endtask

    // stop sending, wait for every predicted result, then let the pipe empty
    task automatic drain_stream();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (blurred_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // setup cycle, then access cycle; register takes the value at the access edge
    task automatic apb_write(t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        apb_sel   <= 1'b1;
        apb_en    <= 1'b0;
        apb_wr    <= 1'b1;
        apb_addr  <= PADDR_W'(int'(idx) << REG_SEL_BIT);
        apb_wdata <= val;
        @(negedge i_clk);
        apb_en <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_IMAGE_WIDTH: cfg_width = val[WIDTH_W-1:0];
            REG_GAIN:        cfg_gain  = val[GAIN_W-1:0];
            default:         ;
        endcase
        @(negedge i_clk);
        // address still selects the register: read it back
        case (idx)
            REG_IMAGE_WIDTH: begin
                if (prdata !== 32'(cfg_width))
                    flag_mismatch("image_width readback", prdata, cfg_width);
            end
            REG_GAIN: begin
                if (prdata !== 32'(cfg_gain))
                    flag_mismatch("gain_q16 readback", prdata, cfg_gain);
            end
            default: ;
        endcase
        apb_sel <= 1'b0;
        apb_en  <= 1'b0;
        apb_wr  <= 1'b0;
    endtask

    // random pixel; channels are pushed to 0 or 255 now and then
    function automatic t_rgb rand_pixel();
        logic [23:0] p;
        p = $urandom;
        for (int ch = 0; ch < 3; ch++) begin
            if ($urandom_range(99) < 15)
                p[ch*CHAN_W +: CHAN_W] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    // one frame at the current width; cut > 0 truncates it, noisy adds stray frame starts
    task automatic send_frame(int rows, int cut, bit noisy, t_rgb fill = '0, bit flat = 0);
        int total;
        total = rows * eff_width(cfg_width);
        if (cut > 0 && cut < total)
            total = cut;
        for (int i = 0; i < total; i++)
            push_pixel(flat ? fill : rand_pixel(),
                       (i == 0) || (noisy && $urandom_range(99) < 2));
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // position counts from (0,0) after reset with no frame start; gain still at reset
    task automatic test_no_frame_start();
        apb_write(REG_IMAGE_WIDTH, 4);
        for (int i = 0; i < 12; i++)
            push_pixel((i % 3 == 0) ? 24'hFFFFFF : (i % 3 == 1) ? 24'h000000 : rand_pixel(),
                       1'b0);
        drain_stream();
    endtask

    // gain extremes: above 7310 saturates, 7281 stays below saturation, 0 blanks
    task automatic test_gain_extremes();
        apb_write(REG_IMAGE_WIDTH, 3);
        apb_write(REG_GAIN, 8191);
        send_frame(3, 0, 0, 24'hFFFFFF, 1);
        drain_stream();
        apb_write(REG_GAIN, 7281);
        send_frame(3, 0, 0, 24'hFFFFFF, 1);
        drain_stream();
        apb_write(REG_GAIN, 0);
        send_frame(3, 0, 0);
        drain_stream();
    endtask

    // width below 3 acts as 3; repeated frame starts hit the same column back to back
    task automatic test_narrow_restart();
        apb_write(REG_IMAGE_WIDTH, 0);
        apb_write(REG_GAIN, GAIN_RESET);
        for (int i = 0; i < 4; i++)
            push_pixel(rand_pixel(), 1'b1);
        send_frame(3, 0, 0);
        drain_stream();
    endtask

    // width above MAX_WIDTH acts as MAX_WIDTH; a short run stays within the first row
    task automatic test_max_width();
        apb_write(REG_IMAGE_WIDTH, 2047);
        send_frame(3, 40, 0);
        drain_stream();
        apb_write(REG_IMAGE_WIDTH, 8);
    endtask

    // random widths, gains and frames under each idling pattern
    task automatic test_random_frames();
        int send_pct [4];
        int recv_pct [4];
        int start_cnt;
        int r;
        send_pct = '{0, 50, 0, 12};
        recv_pct = '{0, 0, 50, 12};
        for (int m = 0; m < 4; m++) begin
            send_idle_pct  = send_pct[m];
            recv_stall_pct = recv_pct[m];
            start_cnt      = pixels_sent;
            while (pixels_sent - start_cnt < 300) begin
                r = $urandom_range(99);
                if (r < 10)
                    apb_write(REG_IMAGE_WIDTH, $urandom_range(2));
                else if (r < 75)
                    apb_write(REG_IMAGE_WIDTH, $urandom_range(3, 10));
                else if (r < 90)
                    apb_write(REG_IMAGE_WIDTH, $urandom_range(11, 40));
                r = $urandom_range(99);
                if (r < 10)
                    apb_write(REG_GAIN, $urandom_range(1) ? 8191 : 0);
                else if (r < 25)
                    apb_write(REG_GAIN, $urandom_range(7282, 8191));
                else if (r < 80)
                    apb_write(REG_GAIN, $urandom_range(7281));
                repeat ($urandom_range(1, 2)) begin
                    // mostly whole frames; some cut short, some with stray restarts
                    send_frame($urandom_range(3, 5),
                               ($urandom_range(99) < 10) ? $urandom_range(1, 30) : 0,
                               $urandom_range(99) < 30);
                end
                drain_stream();
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_no_frame_start();
        test_gain_extremes();
        test_narrow_restart();
        test_max_width();
        test_random_frames();

        drain_stream();
        if (blurred_q.size() != 0)
            flag_mismatch("results never produced", 0, blurred_q.size());
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

### filelist.f
design/bb3_pkg.sv
design/bb3_line_ram.sv
design/rgb_box_blur_3x3_unit.sv
verif/tb.sv
